[hdl/circular_deque_assert.svh]
// Assertion macros shared by the circular deque RTL.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define CDQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define CDQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/cdq_pkg.sv]
// Types, codes and sizes shared by the circular deque modules.
package cdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int RES_MAX   = 16;
	localparam int VALUE_W   = 32;
	localparam int KIND_W    = 3;
	localparam int STAT_W    = 2;
	localparam int CAP_W     = 5;
	localparam int CELL_IW   = $clog2(RES_MAX);
	localparam int CNT_W     = $clog2(RES_MAX + 1);

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DUMP
	} state_t;

	typedef enum logic [2:0] {
		CO_HOLD,
		CO_SHR,
		CO_SHL,
		CO_ROT,
		CO_PUT
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [CELL_IW-1:0]  idx;
	} cell_ctrl_t;

endpackage

[hdl/cdq_cell.sv]
// One storage cell of the deque row, loading from its neighbors, the head cell or the input value.
module cdq_cell
	import cdq_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  cell_ctrl_t                ctrl,
	input  logic signed [VALUE_W-1:0] left_data,
	input  logic signed [VALUE_W-1:0] right_data,
	input  logic signed [VALUE_W-1:0] head_data,
	input  logic signed [VALUE_W-1:0] new_data,
	output logic signed [VALUE_W-1:0] data
);

	logic signed [VALUE_W-1:0] data_q;
	logic                      here;

	assign here = (ctrl.idx == CELL_IW'(IDX));
	assign data = data_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CO_SHR: data_q <= left_data;
			CO_SHL: data_q <= right_data;
			CO_ROT: data_q <= here ? head_data : right_data;
			CO_PUT: if (here) begin
				data_q <= new_data;
			end
			default: data_q <= data_q;
		endcase
	end

endmodule

[hdl/circular_deque.sv]
// Top level of the circular deque: controller, output register and row of cells.
//
//  channel | direction | tdata        | tuser       | other
//  s_      | in        | value (32)   | kind (3)    | -
//  m_      | out       | data (32)    | status (2)  | tlast = last
//  cfg_    | in        | capacity (5) | -           | -
//
// A push or pop has its result in the output register next cycle; an unknown kind gives none.
// A dump of n entries sends n results, the last with tlast, rotating the cell row one place per result.
// The input is not ready while a dump runs or while a result waits for m_tready.
// Reset empties the deque and sets the capacity to the row length.
// A capacity write also empties the deque.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic signed [VALUE_W-1:0] s_tdata,  // value
	input  logic [KIND_W-1:0]         s_tuser,  // kind
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic signed [VALUE_W-1:0] m_tdata,  // data
	output logic [STAT_W-1:0]         m_tuser,  // status
	output logic                      m_tlast,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CAP_W-1:0]          cfg_data
);

	localparam int NCELL = (DEPTH < RES_MAX) ? DEPTH : RES_MAX;

	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          count_q, count_d;
	logic [CNT_W-1:0]          cap_q;
	logic [CNT_W-1:0]          rem_q, rem_d;
	logic [CNT_W-1:0]          cap_eff;
	logic                      m_tvalid_q;
	logic signed [VALUE_W-1:0] m_data_q, out_data;
	logic [STAT_W-1:0]         m_stat_q, out_stat;
	logic                      m_last_q, out_last;
	logic                      out_load, out_free, in_go, cfg_go, full;
	logic [CELL_IW-1:0]        last_idx;
	cell_ctrl_t                ctrl;
	logic signed [VALUE_W-1:0] cell_data [NCELL];

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		cdq_cell #(.IDX(i)) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_data  ((i == 0) ? s_tdata : cell_data[(i == 0) ? 0 : i - 1]),
			.right_data (cell_data[(i == NCELL - 1) ? i : i + 1]),
			.head_data  (cell_data[0]),
			.new_data   (s_tdata),
			.data       (cell_data[i])
		);
	end

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_go     = s_tvalid && s_tready;
	assign cfg_go    = cfg_valid && cfg_ready;
	assign full      = (count_q == cap_q);
	assign last_idx  = CELL_IW'(count_q - CNT_W'(1));

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_stat_q;
	assign m_tlast  = m_last_q;

	always_comb begin
		if (cfg_data == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cfg_data > CAP_W'(NCELL)) begin
			cap_eff = CNT_W'(NCELL);
		end else begin
			cap_eff = CNT_W'(cfg_data);
		end
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		rem_d    = rem_q;
		ctrl.op  = CO_HOLD;
		ctrl.idx = last_idx;
		out_load = 1'b0;
		out_stat = STAT_OK;
		out_data = '0;
		out_last = 1'b1;
		unique case (state_q)
			ST_IDLE: if (in_go) begin
				unique case (s_tuser) inside
					KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
						out_load = 1'b1;
						if (full) begin
							out_stat = STAT_OVERFLOW;
						end else begin
							count_d = count_q + CNT_W'(1);
							if (s_tuser == KIND_PUSH_FRONT) begin
								ctrl.op = CO_SHR;
							end else begin
								ctrl.op  = CO_PUT;
								ctrl.idx = CELL_IW'(count_q);
							end
						end
					end
					KIND_POP_FRONT, KIND_POP_REAR: begin
						out_load = 1'b1;
						if (count_q == '0) begin
							out_stat = STAT_UNDERFLOW;
						end else begin
							count_d = count_q - CNT_W'(1);
							if (s_tuser == KIND_POP_FRONT) begin
								out_data = cell_data[0];
								ctrl.op  = CO_SHL;
							end else begin
								out_data = cell_data[last_idx];
							end
						end
					end
					KIND_DUMP: begin
						if (count_q == '0) begin
							out_load = 1'b1;
							out_stat = STAT_EMPTY;
						end else begin
							state_d = ST_DUMP;
							rem_d   = count_q;
						end
					end
					default: ;
				endcase
			end
			ST_DUMP: if (out_free) begin
				out_load = 1'b1;
				out_data = cell_data[0];
				out_last = (rem_q == CNT_W'(1));
				ctrl.op  = CO_ROT;
				rem_d    = rem_q - CNT_W'(1);
				if (rem_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			cap_q      <= CNT_W'(NCELL);
			rem_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
			if (cfg_go) begin
				cap_q   <= cap_eff;
				count_q <= '0;
			end else begin
				count_q <= count_d;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= out_data;
			m_stat_q <= out_stat;
			m_last_q <= out_last;
		end
	end

	`include "circular_deque_assert.svh"

	`CDQ_ASSERT_ALWAYS(a_count_in_cap, count_q <= cap_q, "entry count exceeds capacity")
	`CDQ_ASSERT_SAME(a_no_input_in_dump, state_q == ST_DUMP, !s_tready, "input taken during dump")
	`CDQ_ASSERT_NEXT(a_overflow_when_full,
		in_go && full && (s_tuser == KIND_PUSH_FRONT || s_tuser == KIND_PUSH_REAR),
		m_tvalid && m_tuser == STAT_OVERFLOW && count_q == $past(count_q),
		"push on a full deque did not report overflow")
	`CDQ_ASSERT_NEXT(a_dump_ends_last,
		state_q == ST_DUMP && out_free && rem_q == CNT_W'(1),
		state_q == ST_IDLE && m_tvalid && m_tlast,
		"dump did not finish with a last transfer")

endmodule
